// ----- rtl/pllm_pkg.sv -----
// package for the pooled linked list manager
// sizes, request and status codes, controller to datapath structs; no dependencies
`default_nettype none

package pllm_pkg;

    localparam int SLOTS    = 16;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int LINK_W   = $clog2(SLOTS + 1);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int REQ_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
    localparam logic [LINK_W-1:0] TOP_SLOT  = LINK_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SLOTS - 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_FRONT  = 3'd0,
        REQ_END    = 3'd1,
        REQ_SORTED = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_DUMP   = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        EM_MISS  = 3'd0,
        EM_EMPTY = 3'd1,
        EM_DUMP  = 3'd2,
        EM_INS   = 3'd3,
        EM_DEL   = 3'd4
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      take_free;
        logic      step;
        logic      unlink_cur;
        logic      relink_nxt;
        logic      link_idx;
        logic      relink_idx;
        logic      emit;
        emit_sel_t emit_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic head_null;
        logic free_null;
        logic cur_valid;
        logic cnt_end;
        logic match;
        logic ge;
        logic dump_last;
        logic out_full;
    } dp_stat_t;

    function automatic logic slot_ok(input logic [LINK_W-1:0] s);
        return s < NULL_LINK;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pllm_ctrl.sv -----
// request sequencer for the pooled linked list manager
// depends on pllm_pkg; drives pllm_dp through ctrl_cmd_t
`default_nettype none

module pllm_ctrl
    import pllm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [REQ_W-1:0] s_req_type,
    input  wire dp_stat_t         stat,
    output ctrl_cmd_t             cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_WALK  = 6'b000100,
        S_DEL   = 6'b001000,
        S_LINK  = 6'b010000,
        S_PUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready && (s_req_type <= REQ_DUMP)) begin
                    cmd.load   = 1'b1;
                    req_next   = req_t'(s_req_type);
                    state_next = S_START;
                end
            end
            S_START: begin
                if (!stat.out_full) begin
                    case (req_reg)
                        REQ_DUMP: begin
                            if (stat.head_null) begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = EM_EMPTY;
                                state_next   = S_IDLE;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        REQ_DELETE: state_next = S_WALK;
                        default: begin
                            if (stat.free_null) begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = EM_MISS;
                                state_next   = S_IDLE;
                            end else begin
                                cmd.take_free = 1'b1;
                                state_next    = (req_reg == REQ_FRONT) ? S_LINK : S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (!stat.out_full) begin
                    case (req_reg)
                        REQ_DUMP: begin
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = EM_DUMP;
                            cmd.step     = 1'b1;
                            if (stat.dump_last) begin
                                state_next = S_IDLE;
                            end
                        end
                        REQ_DELETE: begin
                            if (!stat.cur_valid || stat.cnt_end) begin
                                cmd.emit     = 1'b1;
                                cmd.emit_sel = EM_MISS;
                                state_next   = S_IDLE;
                            end else if (stat.match) begin
                                cmd.unlink_cur = 1'b1;
                                state_next     = S_DEL;
                            end else begin
                                cmd.step = 1'b1;
                            end
                        end
                        default: begin
                            if (!stat.cur_valid || stat.cnt_end ||
                                ((req_reg == REQ_SORTED) && stat.ge)) begin
                                state_next = S_LINK;
                            end else begin
                                cmd.step = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DEL: begin
                if (!stat.out_full) begin
                    cmd.relink_nxt = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EM_DEL;
                    state_next     = S_IDLE;
                end
            end
            S_LINK: begin
                cmd.link_idx = 1'b1;
                state_next   = S_PUT;
            end
            S_PUT: begin
                if (!stat.out_full) begin
                    cmd.relink_idx = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EM_INS;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            req_reg   <= REQ_FRONT;
        end else begin
            state_reg <= state_next;
            req_reg   <= req_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pllm_dp.sv -----
// slot pool datapath: value and link stores, list and free heads, walk cursor, result register
// depends on pllm_pkg; commanded by pllm_ctrl
`default_nettype none

module pllm_dp
    import pllm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ctrl_cmd_t               cmd,
    output dp_stat_t                     stat,
    input  wire logic signed [VAL_W-1:0] s_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [STATUS_W-1:0]          m_status,
    output logic signed [VAL_W-1:0]      m_item_value,
    output logic [SLOT_W-1:0]            m_slot,
    output logic                         m_last
);

    logic signed [VAL_W-1:0] value_reg [SLOTS];
    logic [LINK_W-1:0]       link_reg  [SLOTS];
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [LINK_W-1:0]       free_reg, free_next;
    logic [LINK_W-1:0]       cur_reg, prev_reg, nxt_reg, idx_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [VAL_W-1:0] val_reg;

    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;
    logic signed [VAL_W-1:0] m_item_value_reg, m_item_value_next;
    logic [SLOT_W-1:0]       m_slot_reg, m_slot_next;
    logic                    m_last_reg, m_last_next;

    logic [IDX_W-1:0]        rd_addr;
    logic [LINK_W-1:0]       rd_link;
    logic signed [VAL_W-1:0] rd_val;

    logic                    link_we;
    logic [IDX_W-1:0]        link_waddr;
    logic [LINK_W-1:0]       link_wdata;

    // one read port shared by both stores
    assign rd_addr = cmd.take_free ? idx_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    assign rd_link = link_reg[rd_addr];
    assign rd_val  = value_reg[rd_addr];

    assign stat.head_null = !slot_ok(head_reg);
    assign stat.free_null = !slot_ok(free_reg);
    assign stat.cur_valid = slot_ok(cur_reg);
    assign stat.cnt_end   = (cnt_reg == CNT_END);
    assign stat.match     = (rd_val == val_reg);
    assign stat.ge        = (rd_val >= val_reg);
    assign stat.dump_last = !slot_ok(rd_link) || (cnt_reg == CNT_LAST);
    assign stat.out_full  = m_valid_reg && !m_ready;

    // single write port on the link store, plus head and free pointers
    always_comb begin
        link_we    = 1'b0;
        link_waddr = cur_reg[IDX_W-1:0];
        link_wdata = free_reg;
        head_next  = head_reg;
        free_next  = free_reg;
        if (cmd.take_free) begin
            free_next = rd_link;
        end
        if (cmd.unlink_cur) begin
            link_we    = 1'b1;
            link_waddr = cur_reg[IDX_W-1:0];
            link_wdata = free_reg;
            free_next  = cur_reg;
        end
        if (cmd.link_idx) begin
            link_we    = 1'b1;
            link_waddr = idx_reg[IDX_W-1:0];
            link_wdata = cur_reg;
        end
        if (cmd.relink_nxt || cmd.relink_idx) begin
            if (slot_ok(prev_reg)) begin
                link_we    = 1'b1;
                link_waddr = prev_reg[IDX_W-1:0];
                link_wdata = cmd.relink_nxt ? nxt_reg : idx_reg;
            end else begin
                head_next = cmd.relink_nxt ? nxt_reg : idx_reg;
            end
        end
    end

    always_comb begin
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_item_value_next = m_item_value_reg;
        m_slot_next       = m_slot_reg;
        m_last_next       = m_last_reg;
        if (cmd.emit) begin
            m_valid_next      = 1'b1;
            m_status_next     = ST_DONE;
            m_item_value_next = val_reg;
            m_slot_next       = '0;
            m_last_next       = 1'b1;
            case (cmd.emit_sel)
                EM_MISS: m_status_next = ST_MISS;
                EM_EMPTY: begin
                    m_status_next     = ST_EMPTY;
                    m_item_value_next = '0;
                end
                EM_DUMP: begin
                    m_item_value_next = rd_val;
                    m_slot_next       = SLOT_W'(cur_reg);
                    m_last_next       = stat.dump_last;
                end
                EM_INS:  m_slot_next = SLOT_W'(idx_reg);
                EM_DEL:  m_slot_next = SLOT_W'(cur_reg);
                default: m_status_next = ST_MISS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                link_reg[i] <= (i == 0) ? NULL_LINK : LINK_W'(i - 1);
            end
            head_reg    <= NULL_LINK;
            free_reg    <= TOP_SLOT;
            m_valid_reg <= 1'b0;
        end else begin
            if (link_we) begin
                link_reg[link_waddr] <= link_wdata;
            end
            head_reg    <= head_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_free) begin
            value_reg[idx_reg[IDX_W-1:0]] <= val_reg;
        end
        if (cmd.load) begin
            val_reg  <= s_value;
            cur_reg  <= head_reg;
            prev_reg <= NULL_LINK;
            cnt_reg  <= '0;
            idx_reg  <= free_reg;
        end
        if (cmd.step) begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_link;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.unlink_cur) begin
            nxt_reg <= rd_link;
        end
        m_status_reg     <= m_status_next;
        m_item_value_reg <= m_item_value_next;
        m_slot_reg       <= m_slot_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_item_value = m_item_value_reg;
    assign m_slot       = m_slot_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

// ----- rtl/pooled_linked_list_manager_core.sv -----
// top level of the pooled linked list manager: sequencer plus slot pool datapath
// depends on pllm_pkg, pllm_ctrl, pllm_dp
//
//   channel   ports                                   direction
//   request   s_valid s_ready s_req_type s_value      in
//   result    m_valid m_ready m_status m_item_value   out
//             m_slot m_last
//
// a request is taken only while the sequencer is idle: an accept step, a setup
// step, a walk step per slot visited, then the relink in S_DEL, or in S_LINK and
// S_PUT for an insert; a full pool or an empty dump ends at setup
// a dump emits one item per walk cycle; any step that emits waits while the
// result register is full and not taken
// reset restores the free chain top slot down to slot 0
`default_nettype none

module pooled_linked_list_manager_core
    import pllm_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [REQ_W-1:0]        s_req_type,
    input  wire logic signed [VAL_W-1:0] s_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [STATUS_W-1:0]          m_status,
    output logic signed [VAL_W-1:0]      m_item_value,
    output logic [SLOT_W-1:0]            m_slot,
    output logic                         m_last
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pllm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .stat       (stat),
        .cmd        (cmd)
    );

    pllm_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_item_value (m_item_value),
        .m_slot       (m_slot),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
